/* hw/rtl/rbsi_pkg.sv */
// Shared types and constants for the ray/box slab intersection block.
// No dependencies; used by rbsi_slab_div and ray_box_slab_intersect.
package rbsi_pkg;

    // Q16.16 fraction bits
    localparam int Q_FRAC = 16;
    // Slab difference magnitude: |plane - origin| < 2^33
    localparam int DIFF_W = 33;
    // Dividend width: difference scaled by 2^16
    localparam int NUM_W  = DIFF_W + Q_FRAC;
    // Divisor magnitude: |dir| <= 2^31
    localparam int DEN_W  = 32;
    // Signed slab parameter width, with room for the no-limit markers
    localparam int T_W    = NUM_W + 3;
    localparam logic signed [T_W-1:0] NO_LIMIT = T_W'(1) <<< (NUM_W + 1);
    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] box_center_x;
        logic signed [31:0] box_center_y;
        logic signed [31:0] box_center_z;
        logic [30:0]        box_half_x;
        logic [30:0]        box_half_y;
        logic [30:0]        box_half_z;
        logic signed [31:0] ray_origin_x;
        logic signed [31:0] ray_origin_y;
        logic signed [31:0] ray_origin_z;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic signed [31:0] ray_dir_z;
    } rbsi_in_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] hit_distance;
    } rbsi_out_t;

    // Per-axis flags that ride along with the divider
    typedef struct packed {
        logic neg_lo;   // quotient for the low plane is negative
        logic neg_hi;   // quotient for the high plane is negative
        logic dzero;    // direction is zero on this axis
        logic in_slab;  // origin lies within this slab
    } rbsi_sb_t;

endpackage

/* hw/rtl/rbsi_slab_div.sv */
// Pipelined restoring divider for one axis: two dividends, shared divisor.
// One quotient bit per stage, NUM_W stages. Depends on rbsi_pkg.
module rbsi_slab_div #(
    parameter int NUM_W = rbsi_pkg::NUM_W,
    parameter int DEN_W = rbsi_pkg::DEN_W
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num_lo,
    input  logic [NUM_W-1:0]     num_hi,
    input  logic [DEN_W-1:0]     den,
    input  rbsi_pkg::rbsi_sb_t   sb_in,
    output logic [NUM_W-1:0]     quo_lo,
    output logic [NUM_W-1:0]     quo_hi,
    output rbsi_pkg::rbsi_sb_t   sb_out
);
    import rbsi_pkg::*;

    // Per stage: partial remainders, dividend bits shifting out as quotient shifts in
    logic [DEN_W-1:0] rlo_reg [NUM_W];
    logic [DEN_W-1:0] rhi_reg [NUM_W];
    logic [NUM_W-1:0] qlo_reg [NUM_W];
    logic [NUM_W-1:0] qhi_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    rbsi_sb_t         sb_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W-1:0] rlo_prev, rhi_prev, den_prev;
        logic [NUM_W-1:0] qlo_prev, qhi_prev;
        rbsi_sb_t         sb_prev;
        logic [DEN_W:0]   tlo, thi, dext;
        logic             ge_lo, ge_hi;
        logic [DEN_W-1:0] rlo_next, rhi_next;

        if (k == 0) begin : g_first
            assign rlo_prev = '0;
            assign rhi_prev = '0;
            assign qlo_prev = num_lo;
            assign qhi_prev = num_hi;
            assign den_prev = den;
            assign sb_prev  = sb_in;
        end else begin : g_rest
            assign rlo_prev = rlo_reg[k-1];
            assign rhi_prev = rhi_reg[k-1];
            assign qlo_prev = qlo_reg[k-1];
            assign qhi_prev = qhi_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign sb_prev  = sb_reg[k-1];
        end

        // Bring down the next dividend bit, subtract if it fits
        assign dext  = {1'b0, den_prev};
        assign tlo   = {rlo_prev, qlo_prev[NUM_W-1]};
        assign thi   = {rhi_prev, qhi_prev[NUM_W-1]};
        assign ge_lo = (tlo >= dext);
        assign ge_hi = (thi >= dext);
        assign rlo_next = ge_lo ? DEN_W'(tlo - dext) : tlo[DEN_W-1:0];
        assign rhi_next = ge_hi ? DEN_W'(thi - dext) : thi[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                rlo_reg[k] <= rlo_next;
                rhi_reg[k] <= rhi_next;
                qlo_reg[k] <= {qlo_prev[NUM_W-2:0], ge_lo};
                qhi_reg[k] <= {qhi_prev[NUM_W-2:0], ge_hi};
                den_reg[k] <= den_prev;
                sb_reg[k]  <= sb_prev;
            end
        end
    end

    assign quo_lo = qlo_reg[NUM_W-1];
    assign quo_hi = qhi_reg[NUM_W-1];
    assign sb_out = sb_reg[NUM_W-1];

endmodule

/* hw/rtl/ray_box_slab_intersect.sv */
// Ray versus axis-aligned box, slab method, fully pipelined.
// Depends on rbsi_pkg and rbsi_slab_div.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one test: box center, half
//   extents, ray origin and direction, all Q16.16. Result channel
//   m_valid/m_ready/m_data returns hit and the saturated hit distance.
//   Exactly one result per input transfer, in order.
// Latency: 54 register stages: the one-bit-per-stage divider (49 stages)
//   plus prep, sign, per-axis, combine and output stages.
// Throughput: one test per cycle unless stalled. Three axis dividers run
//   in parallel, each resolving both slab planes against the shared direction.
// Stall: the whole pipeline advances together; while m_valid is high and
//   m_ready is low every stage holds and s_ready drops. No item is lost or
//   repeated, and bubbles ride through as invalid stages.
// Reset: aresetn (synchronous, active low) clears all valid bits; the
//   block is ready for a transfer in the first cycle after reset.
module ray_box_slab_intersect (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rbsi_pkg::rbsi_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rbsi_pkg::rbsi_out_t m_data
);
    import rbsi_pkg::*;

    localparam int PIPE_D = NUM_W + 5;

    logic              en;
    logic [PIPE_D-1:0] vld_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_D-1];

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_D-2:0], s_valid};
        end
    end

    logic signed [31:0] c_ax [3];
    logic [30:0]        h_ax [3];
    logic signed [31:0] o_ax [3];
    logic signed [31:0] d_ax [3];

    assign c_ax[0] = s_data.box_center_x;
    assign c_ax[1] = s_data.box_center_y;
    assign c_ax[2] = s_data.box_center_z;
    assign h_ax[0] = s_data.box_half_x;
    assign h_ax[1] = s_data.box_half_y;
    assign h_ax[2] = s_data.box_half_z;
    assign o_ax[0] = s_data.ray_origin_x;
    assign o_ax[1] = s_data.ray_origin_y;
    assign o_ax[2] = s_data.ray_origin_z;
    assign d_ax[0] = s_data.ray_dir_x;
    assign d_ax[1] = s_data.ray_dir_y;
    assign d_ax[2] = s_data.ray_dir_z;

    // Per-axis clipped interval after the dividers
    logic signed [T_W-1:0] near_ax_reg [3];
    logic signed [T_W-1:0] far_ax_reg  [3];
    logic [2:0]            ok_ax_reg;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [DIFF_W+1:0] dlo, dhi;
        logic [DIFF_W-1:0]        mlo, mhi;
        logic [DEN_W-1:0]         md;
        rbsi_sb_t                 sb_next;
        logic [NUM_W-1:0]         nlo_reg, nhi_reg;
        logic [DEN_W-1:0]         den_reg;
        rbsi_sb_t                 sb_reg;
        logic [NUM_W-1:0]         qlo, qhi;
        rbsi_sb_t                 sb_div;
        logic signed [T_W-1:0]    tlo_reg, thi_reg;
        rbsi_sb_t                 sb_t_reg;

        // Prep: plane minus origin, magnitudes and signs
        assign dlo = (DIFF_W+2)'(c_ax[a]) - (DIFF_W+2)'({1'b0, h_ax[a]})
                     - (DIFF_W+2)'(o_ax[a]);
        assign dhi = (DIFF_W+2)'(c_ax[a]) + (DIFF_W+2)'({1'b0, h_ax[a]})
                     - (DIFF_W+2)'(o_ax[a]);
        assign mlo = dlo[DIFF_W+1] ? DIFF_W'(-dlo) : DIFF_W'(dlo);
        assign mhi = dhi[DIFF_W+1] ? DIFF_W'(-dhi) : DIFF_W'(dhi);
        assign md  = d_ax[a][31] ? DEN_W'(-d_ax[a]) : DEN_W'(d_ax[a]);
        assign sb_next.neg_lo  = dlo[DIFF_W+1] ^ d_ax[a][31];
        assign sb_next.neg_hi  = dhi[DIFF_W+1] ^ d_ax[a][31];
        assign sb_next.dzero   = (d_ax[a] == '0);
        assign sb_next.in_slab = (dlo <= 0) && (dhi >= 0);

        always_ff @(posedge aclk) begin
            if (en) begin
                nlo_reg <= {mlo, Q_FRAC'(0)};
                nhi_reg <= {mhi, Q_FRAC'(0)};
                den_reg <= md;
                sb_reg  <= sb_next;
            end
        end

        rbsi_slab_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .aclk   (aclk),
            .en     (en),
            .num_lo (nlo_reg),
            .num_hi (nhi_reg),
            .den    (den_reg),
            .sb_in  (sb_reg),
            .quo_lo (qlo),
            .quo_hi (qhi),
            .sb_out (sb_div)
        );

        // Apply quotient sign (truncation toward zero)
        always_ff @(posedge aclk) begin
            if (en) begin
                tlo_reg  <= sb_div.neg_lo ? -T_W'(qlo) : T_W'(qlo);
                thi_reg  <= sb_div.neg_hi ? -T_W'(qhi) : T_W'(qhi);
                sb_t_reg <= sb_div;
            end
        end

        // Order the two planes; a zero direction sets no limit
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sb_t_reg.dzero) begin
                    near_ax_reg[a] <= -NO_LIMIT;
                    far_ax_reg[a]  <= NO_LIMIT;
                end else if (tlo_reg < thi_reg) begin
                    near_ax_reg[a] <= tlo_reg;
                    far_ax_reg[a]  <= thi_reg;
                end else begin
                    near_ax_reg[a] <= thi_reg;
                    far_ax_reg[a]  <= tlo_reg;
                end
                ok_ax_reg[a] <= !sb_t_reg.dzero || sb_t_reg.in_slab;
            end
        end
    end

    // Combine axes: entry is the greatest near, exit the least far
    logic signed [T_W-1:0] n01, f01, near_next, far_next;
    logic signed [T_W-1:0] near_reg, far_reg;
    logic                  ok_reg;

    assign n01       = (near_ax_reg[0] > near_ax_reg[1]) ? near_ax_reg[0] : near_ax_reg[1];
    assign near_next = (n01 > near_ax_reg[2]) ? n01 : near_ax_reg[2];
    assign f01       = (far_ax_reg[0] < far_ax_reg[1]) ? far_ax_reg[0] : far_ax_reg[1];
    assign far_next  = (f01 < far_ax_reg[2]) ? f01 : far_ax_reg[2];

    always_ff @(posedge aclk) begin
        if (en) begin
            near_reg <= near_next;
            far_reg  <= far_next;
            ok_reg   <= &ok_ax_reg;
        end
    end

    // Hit decision and saturated distance
    logic signed [T_W-1:0] dist_sel;
    logic                  hit_next;
    rbsi_out_t             out_next;
    rbsi_out_t             out_reg;

    assign dist_sel = near_reg[T_W-1] ? far_reg : near_reg;
    assign hit_next = ok_reg && !far_reg[T_W-1] && (far_reg >= near_reg);

    always_comb begin
        out_next.hit = hit_next;
        if (!hit_next) begin
            out_next.hit_distance = '0;
        end else if (dist_sel > T_W'(DIST_MAX)) begin
            out_next.hit_distance = DIST_MAX;
        end else begin
            out_next.hit_distance = dist_sel[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule
